### src/spp_pkg.sv
// Shared types and constants for the sprite screen projection block.
`default_nettype none
package spp_pkg;
  localparam int DIR_FRAC_BITS = 14;
  localparam int OFFSET_W = 24;
  localparam int CFG_W = 16;
  localparam int PIX_W = 12;
  localparam int QUOT_W = 17;
  localparam int COL_NUM_W = 52;
  localparam int NY_MAG_W = 40;
  localparam int DET_MAG_W = 32;
  localparam int SZ_BASE_W = 44;
  localparam int FRONT_STAGES = 4;
  localparam int BACK_STAGES = 2;

  localparam logic signed [15:0] COL_MAX = 16'sh7FFF;
  localparam logic signed [15:0] COL_MIN = 16'sh8000;
  localparam logic [15:0] SIZE_MAX = 16'hFFFF;

  localparam logic [15:0] DIR_X_RESET = 16'd16384;
  localparam logic [15:0] DIR_Y_RESET = 16'd0;
  localparam logic [15:0] PLANE_X_RESET = 16'd0;
  localparam logic [15:0] PLANE_Y_RESET = 16'd10813;
  localparam logic [11:0] WIDTH_RESET = 12'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;

  typedef enum logic [2:0] {
    REG_DIR_X,
    REG_DIR_Y,
    REG_PLANE_X,
    REG_PLANE_Y,
    REG_SCREEN_WIDTH,
    REG_SCREEN_HEIGHT
  } reg_idx_t;

  typedef struct packed {
    logic col_neg;
    logic nx_pos;
    logic nx_neg;
  } col_side_t;

  typedef struct packed {
    logic det_zero;
    logic ny_zero;
    logic flag;
  } sz_side_t;
endpackage
`default_nettype wire

### src/spp_ctl.sv
// Valid chain and per-stage advance enables with bubble collapse.
`default_nettype none
module spp_ctl #(
  parameter int STAGES = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_stall,
  output logic [STAGES-1:0] adv,
  output logic [STAGES-1:0] vld
);
  logic [STAGES:0]   go;
  logic [STAGES-1:0] feed;

  assign go[STAGES] = !out_stall;
  assign feed = {vld[STAGES-2:0], in_valid};
  assign adv = go[STAGES-1:0];

  for (genvar k = 0; k < STAGES; k++) begin : g_go
    assign go[k] = !vld[k] || go[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (go[k]) begin
          vld[k] <= feed[k];
        end
      end
    end
  end
endmodule
`default_nettype wire

### src/spp_front.sv
// Camera transform: products, numerators, magnitudes and divider operands.
`default_nettype none
module spp_front #(
  parameter int OFFSET_FRAC_BITS = 12
) (
  input  logic                     clk,
  input  logic [3:0]               adv,
  input  logic signed [15:0]       dir_x,
  input  logic signed [15:0]       dir_y,
  input  logic signed [15:0]       plane_x,
  input  logic signed [15:0]       plane_y,
  input  logic [11:0]              screen_width,
  input  logic [11:0]              screen_height,
  input  logic signed [23:0]       offset_x,
  input  logic signed [23:0]       offset_y,
  output logic [spp_pkg::COL_NUM_W-1:0] col_num,
  output logic [spp_pkg::NY_MAG_W-1:0]  col_den,
  output logic [spp_pkg::SZ_BASE_W+((OFFSET_FRAC_BITS > spp_pkg::DIR_FRAC_BITS) ?
                (OFFSET_FRAC_BITS - spp_pkg::DIR_FRAC_BITS) : 0)-1:0] sz_num,
  output logic [spp_pkg::NY_MAG_W+((OFFSET_FRAC_BITS < spp_pkg::DIR_FRAC_BITS) ?
                (spp_pkg::DIR_FRAC_BITS - OFFSET_FRAC_BITS) : 0)-1:0] sz_den,
  output spp_pkg::col_side_t       col_side,
  output spp_pkg::sz_side_t        sz_side
);
  localparam int SZ_SHL = (OFFSET_FRAC_BITS > spp_pkg::DIR_FRAC_BITS) ?
                          (OFFSET_FRAC_BITS - spp_pkg::DIR_FRAC_BITS) : 0;
  localparam int SZ_SHR = (OFFSET_FRAC_BITS < spp_pkg::DIR_FRAC_BITS) ?
                          (spp_pkg::DIR_FRAC_BITS - OFFSET_FRAC_BITS) : 0;
  localparam int SZ_NUM_W = spp_pkg::SZ_BASE_W + SZ_SHL;
  localparam int SZ_DEN_W = spp_pkg::NY_MAG_W + SZ_SHR;

  logic signed [39:0] p_dyox, p_dxoy, p_pxoy, p_pyox;
  logic signed [31:0] p_pxdy, p_dxpy;
  logic signed [40:0] nx, ny;
  logic signed [41:0] sum;
  logic signed [32:0] det;
  logic [spp_pkg::NY_MAG_W-1:0]  ny_mag;
  logic [spp_pkg::DET_MAG_W-1:0] det_mag;
  logic [40:0]                   sum_mag;
  spp_pkg::col_side_t            cs;
  spp_pkg::sz_side_t             ss;
  logic det_pos, ny_pos;

  assign det_pos = !det[32] && (det != '0);
  assign ny_pos = !ny[40] && (ny != '0);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p_dyox <= 40'(dir_y) * 40'(offset_x);
      p_dxoy <= 40'(dir_x) * 40'(offset_y);
      p_pxoy <= 40'(plane_x) * 40'(offset_y);
      p_pyox <= 40'(plane_y) * 40'(offset_x);
      p_pxdy <= 32'(plane_x) * 32'(dir_y);
      p_dxpy <= 32'(dir_x) * 32'(plane_y);
    end
    if (adv[1]) begin
      nx  <= 41'(p_dyox) - 41'(p_dxoy);
      ny  <= 41'(p_pxoy) - 41'(p_pyox);
      sum <= 42'(p_dyox) - 42'(p_dxoy) + 42'(p_pxoy) - 42'(p_pyox);
      det <= 33'(p_pxdy) - 33'(p_dxpy);
    end
    if (adv[2]) begin
      ny_mag     <= ny[40] ? spp_pkg::NY_MAG_W'(-ny) : spp_pkg::NY_MAG_W'(ny);
      det_mag    <= det[32] ? spp_pkg::DET_MAG_W'(-det) : spp_pkg::DET_MAG_W'(det);
      sum_mag    <= sum[41] ? 41'(-sum) : 41'(sum);
      cs.col_neg <= sum[41] ^ ny[40];
      cs.nx_pos  <= !nx[40] && (nx != '0);
      cs.nx_neg  <= nx[40];
      ss.det_zero <= (det == '0);
      ss.ny_zero  <= (ny == '0);
      ss.flag     <= (det == '0) || (ny == '0) || (det_pos != ny_pos);
    end
    if (adv[3]) begin
      col_num  <= spp_pkg::COL_NUM_W'(screen_width[11:1]) * spp_pkg::COL_NUM_W'(sum_mag);
      col_den  <= ny_mag;
      sz_num   <= (SZ_NUM_W'(det_mag) * SZ_NUM_W'(screen_height)) << SZ_SHL;
      sz_den   <= SZ_DEN_W'(ny_mag) << SZ_SHR;
      col_side <= cs;
      sz_side  <= ss;
    end
  end
endmodule
`default_nettype wire

### src/spp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`default_nettype none
module spp_div #(
  parameter int NUM_W = 52,
  parameter int DEN_W = 40,
  parameter int Q_W = 17,
  parameter int SIDE_W = 3
) (
  input  logic              clk,
  input  logic [Q_W:0]      adv,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic [Q_W-1:0]    quot,
  output logic              ovf,
  output logic [SIDE_W-1:0] side_out
);
  localparam int CW = ((NUM_W > DEN_W + Q_W) ? NUM_W : (DEN_W + Q_W)) + 1;

  logic [NUM_W-1:0]  r [Q_W+1];
  logic [DEN_W-1:0]  d [Q_W+1];
  logic [Q_W-1:0]    q [Q_W+1];
  logic              o [Q_W+1];
  logic [SIDE_W-1:0] s [Q_W+1];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      r[0] <= num;
      d[0] <= den;
      q[0] <= '0;
      o[0] <= CW'(num) >= (CW'(den) << Q_W);
      s[0] <= side_in;
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    localparam int SH = Q_W - k;
    logic [CW-1:0] shifted;
    logic [CW-1:0] diff;
    logic          take;

    assign shifted = CW'(d[k-1]) << SH;
    assign diff = CW'(r[k-1]) - shifted;
    assign take = CW'(r[k-1]) >= shifted;

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        r[k] <= take ? NUM_W'(diff) : r[k-1];
        d[k] <= d[k-1];
        q[k] <= {q[k-1][Q_W-2:0], take};
        o[k] <= o[k-1];
        s[k] <= s[k-1];
      end
    end
  end

  assign quot = q[Q_W];
  assign ovf = o[Q_W];
  assign side_out = s[Q_W];
endmodule
`default_nettype wire

### src/spp_back.sv
// Quotient saturation, special cases and draw bound clamping.
`default_nettype none
module spp_back (
  input  logic                 clk,
  input  logic [1:0]           adv,
  input  logic [11:0]          screen_width,
  input  logic [11:0]          screen_height,
  input  logic [spp_pkg::QUOT_W-1:0] col_q,
  input  logic                 col_ovf,
  input  spp_pkg::col_side_t   col_side,
  input  logic [spp_pkg::QUOT_W-1:0] sz_q,
  input  logic                 sz_ovf,
  input  spp_pkg::sz_side_t    sz_side,
  output logic signed [15:0]   screen_column,
  output logic [15:0]          sprite_size,
  output logic [14:0]          start_row,
  output logic signed [15:0]   end_row,
  output logic [14:0]          start_column,
  output logic signed [15:0]   end_column,
  output logic                 depth_not_positive
);
  logic signed [15:0] half, col_n, col_r;
  logic [15:0]        size_n, size_r;
  logic               flag_r;
  logic signed [17:0] hs, hh, hv, wv, v_sr, v_er, v_sc, v_ec;

  assign half = {5'd0, screen_width[11:1]};

  always_comb begin
    col_n = half;
    size_n = '0;
    if (sz_side.det_zero) begin
      col_n = half;
      size_n = '0;
    end else if (sz_side.ny_zero) begin
      size_n = spp_pkg::SIZE_MAX;
      if (col_side.nx_pos) begin
        col_n = spp_pkg::COL_MAX;
      end else if (col_side.nx_neg) begin
        col_n = spp_pkg::COL_MIN;
      end else begin
        col_n = half;
      end
    end else begin
      size_n = (sz_ovf || sz_q[spp_pkg::QUOT_W-1]) ? spp_pkg::SIZE_MAX : sz_q[15:0];
      if (col_side.col_neg) begin
        col_n = (col_ovf || col_q > 17'd32768) ? spp_pkg::COL_MIN : 16'(17'd0 - col_q);
      end else begin
        col_n = (col_ovf || col_q > 17'd32767) ? spp_pkg::COL_MAX : 16'(col_q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      col_r  <= col_n;
      size_r <= size_n;
      flag_r <= sz_side.flag;
    end
  end

  assign hs = {3'd0, size_r[15:1]};
  assign hh = {7'd0, screen_height[11:1]};
  assign hv = {6'd0, screen_height};
  assign wv = {6'd0, screen_width};
  assign v_sr = hh - hs;
  assign v_er = hs + hh;
  assign v_sc = 18'(col_r) - hs;
  assign v_ec = 18'(col_r) + hs;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      screen_column      <= col_r;
      sprite_size        <= size_r;
      start_row          <= v_sr[17] ? 15'd0 : 15'(v_sr);
      end_row            <= (v_er >= hv) ? 16'(hv - 18'sd1) : 16'(v_er);
      start_column       <= v_sc[17] ? 15'd0 : 15'(v_sc);
      end_column         <= (v_ec >= wv) ? 16'(wv - 18'sd1) : 16'(v_ec);
      depth_not_positive <= flag_r;
    end
  end
endmodule
`default_nettype wire

### src/sprite_screen_projection.sv
// Sprite screen projection top level: register file, pipeline and checks.
// Projects one sprite offset per cycle, while the input is not stalled,
// through the inverse camera matrix and gives screen column, size and
// clamped draw bounds. A word passes four transform stages, two 18-stage
// restoring dividers running side by side (one quotient bit per stage, plus
// an overflow check), and two output stages. One word enters every cycle;
// bubbles collapse, so input is stalled only when every stage holds a word
// and the output is stalled. Write registers only while the block is empty.
`default_nettype none
module sprite_screen_projection #(
  parameter int OFFSET_FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [23:0] offset_x,
  input  logic signed [23:0] offset_y,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [15:0] screen_column,
  output logic [15:0]        sprite_size,
  output logic [14:0]        start_row,
  output logic signed [15:0] end_row,
  output logic [14:0]        start_column,
  output logic signed [15:0] end_column,
  output logic               depth_not_positive
);
  localparam int SZ_SHL = (OFFSET_FRAC_BITS > spp_pkg::DIR_FRAC_BITS) ?
                          (OFFSET_FRAC_BITS - spp_pkg::DIR_FRAC_BITS) : 0;
  localparam int SZ_SHR = (OFFSET_FRAC_BITS < spp_pkg::DIR_FRAC_BITS) ?
                          (spp_pkg::DIR_FRAC_BITS - OFFSET_FRAC_BITS) : 0;
  localparam int SZ_NUM_W = spp_pkg::SZ_BASE_W + SZ_SHL;
  localparam int SZ_DEN_W = spp_pkg::NY_MAG_W + SZ_SHR;
  localparam int DIV_STAGES = spp_pkg::QUOT_W + 1;
  localparam int STAGES = spp_pkg::FRONT_STAGES + DIV_STAGES + spp_pkg::BACK_STAGES;
  localparam int DIV_LO = spp_pkg::FRONT_STAGES;
  localparam int BACK_LO = DIV_LO + DIV_STAGES;

  logic signed [15:0] dir_x, dir_y, plane_x, plane_y;
  logic [11:0]        screen_width, screen_height;
  logic [STAGES-1:0]  adv, vld;

  logic [spp_pkg::COL_NUM_W-1:0] col_num;
  logic [spp_pkg::NY_MAG_W-1:0]  col_den;
  logic [SZ_NUM_W-1:0]           sz_num;
  logic [SZ_DEN_W-1:0]           sz_den;
  spp_pkg::col_side_t            col_side_f, col_side_d;
  spp_pkg::sz_side_t             sz_side_f, sz_side_d;
  logic [spp_pkg::QUOT_W-1:0]    col_q, sz_q;
  logic                          col_ovf, sz_ovf;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_x         <= spp_pkg::DIR_X_RESET;
      dir_y         <= spp_pkg::DIR_Y_RESET;
      plane_x       <= spp_pkg::PLANE_X_RESET;
      plane_y       <= spp_pkg::PLANE_Y_RESET;
      screen_width  <= spp_pkg::WIDTH_RESET;
      screen_height <= spp_pkg::HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (spp_pkg::reg_idx_t'(paddr[4:2]))
        spp_pkg::REG_DIR_X:         dir_x <= pwdata[15:0];
        spp_pkg::REG_DIR_Y:         dir_y <= pwdata[15:0];
        spp_pkg::REG_PLANE_X:       plane_x <= pwdata[15:0];
        spp_pkg::REG_PLANE_Y:       plane_y <= pwdata[15:0];
        spp_pkg::REG_SCREEN_WIDTH:  screen_width <= pwdata[11:0];
        spp_pkg::REG_SCREEN_HEIGHT: screen_height <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (spp_pkg::reg_idx_t'(paddr[4:2]))
      spp_pkg::REG_DIR_X:         prdata = {16'd0, dir_x};
      spp_pkg::REG_DIR_Y:         prdata = {16'd0, dir_y};
      spp_pkg::REG_PLANE_X:       prdata = {16'd0, plane_x};
      spp_pkg::REG_PLANE_Y:       prdata = {16'd0, plane_y};
      spp_pkg::REG_SCREEN_WIDTH:  prdata = {20'd0, screen_width};
      spp_pkg::REG_SCREEN_HEIGHT: prdata = {20'd0, screen_height};
      default:                    prdata = '0;
    endcase
  end

  spp_ctl #(.STAGES(STAGES)) u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .out_stall (result_stall),
    .adv       (adv),
    .vld       (vld)
  );

  assign item_stall = !adv[0];
  assign result_valid = vld[STAGES-1];

  spp_front #(.OFFSET_FRAC_BITS(OFFSET_FRAC_BITS)) u_front (
    .clk           (clk),
    .adv           (adv[spp_pkg::FRONT_STAGES-1:0]),
    .dir_x         (dir_x),
    .dir_y         (dir_y),
    .plane_x       (plane_x),
    .plane_y       (plane_y),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .offset_x      (offset_x),
    .offset_y      (offset_y),
    .col_num       (col_num),
    .col_den       (col_den),
    .sz_num        (sz_num),
    .sz_den        (sz_den),
    .col_side      (col_side_f),
    .sz_side       (sz_side_f)
  );

  spp_div #(
    .NUM_W  (spp_pkg::COL_NUM_W),
    .DEN_W  (spp_pkg::NY_MAG_W),
    .Q_W    (spp_pkg::QUOT_W),
    .SIDE_W ($bits(spp_pkg::col_side_t))
  ) u_col_div (
    .clk      (clk),
    .adv      (adv[BACK_LO-1:DIV_LO]),
    .num      (col_num),
    .den      (col_den),
    .side_in  (col_side_f),
    .quot     (col_q),
    .ovf      (col_ovf),
    .side_out (col_side_d)
  );

  spp_div #(
    .NUM_W  (SZ_NUM_W),
    .DEN_W  (SZ_DEN_W),
    .Q_W    (spp_pkg::QUOT_W),
    .SIDE_W ($bits(spp_pkg::sz_side_t))
  ) u_sz_div (
    .clk      (clk),
    .adv      (adv[BACK_LO-1:DIV_LO]),
    .num      (sz_num),
    .den      (sz_den),
    .side_in  (sz_side_f),
    .quot     (sz_q),
    .ovf      (sz_ovf),
    .side_out (sz_side_d)
  );

  spp_back u_back (
    .clk                (clk),
    .adv                (adv[STAGES-1:BACK_LO]),
    .screen_width       (screen_width),
    .screen_height      (screen_height),
    .col_q              (col_q),
    .col_ovf            (col_ovf),
    .col_side           (col_side_d),
    .sz_q               (sz_q),
    .sz_ovf             (sz_ovf),
    .sz_side            (sz_side_d),
    .screen_column      (screen_column),
    .sprite_size        (sprite_size),
    .start_row          (start_row),
    .end_row            (end_row),
    .start_column       (start_column),
    .end_column         (end_column),
    .depth_not_positive (depth_not_positive)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (&vld))
    else $error("input stalled with a free stage");

  a_end_row_below_height: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (end_row < $signed({4'd0, screen_height})))
    else $error("end row not clamped to height");

  a_start_row_in_half: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ({4'd0, start_row} <= {8'd0, screen_height[11:1]}))
    else $error("start row beyond half height");
endmodule
`default_nettype wire
